/* rtl/core/multi_channel_dma_address_engine_top_defines.svh */
// Assertion macros for the DMA address engine.
`ifndef MULTI_CHANNEL_DMA_ADDRESS_ENGINE_TOP_DEFINES_SVH
`define MULTI_CHANNEL_DMA_ADDRESS_ENGINE_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define DMA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dma assertion failed");
`define DMA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dma assertion failed");
`else
`define DMA_ASSERT_IMPL(label, ante, cons)
`define DMA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* rtl/core/mcdma_pkg.sv */
// Package: shared types and constants of the DMA address engine.
`timescale 1ns / 1ps
`default_nettype none
package mcdma_pkg;
    localparam int NUM_CHANNELS_DEF = 8;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        FN_WR_SRC   = 3'd0,
        FN_WR_DST   = 3'd1,
        FN_WR_TOTAL = 3'd2,
        FN_WR_BLOCK = 3'd3,
        FN_WR_CTRL  = 3'd4,
        FN_DRQ_SET  = 3'd5,
        FN_DRQ_CLR  = 3'd6,
        FN_STEP     = 3'd7
    } func_t;

    typedef enum logic [1:0] {
        ST_NONE = 2'd0,
        ST_WORD = 2'd1,
        ST_SKIP = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0]  func;
        logic [2:0]  chan;
        logic [31:0] write_mask;
        logic [31:0] write_value;
        logic [4:0]  drq_type;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [2:0]  xfer_channel;
        logic        block_end;
        logic        irq_raise;
        logic [7:0]  enabled_mask;
        logic [7:0]  pending_mask;
    } res_t;

    localparam logic [31:0] ADDR_MASK  = 32'hFFFF_FFFC;
    localparam logic [31:0] TOTAL_MASK = 32'h0FFF_FFFF;
    localparam logic [31:0] BLOCK_MASK = 32'h00FF_FFFF;
    localparam logic [31:0] CTRL_MASK  = 32'hFF0F_FFFF;
    localparam logic [31:0] FILL_BASE  = 32'h1000_2018;
    localparam logic [31:0] FILL_STEP  = 32'h0000_001C;
    localparam logic [24:0] BLOCK_MAX  = 25'h100_0000;
    localparam logic [31:0] PAIR_A     = 32'h0000_0140;
    localparam logic [31:0] PAIR_B     = 32'h0000_0600;
    localparam logic [4:0]  MODE_PAIR  = 5'h0F;

    function automatic logic [31:0] step_of(input logic [1:0] sel);
        logic [31:0] r;
        begin
            case (sel)
                2'd0:    r = 32'd4;
                2'd1:    r = 32'hFFFF_FFFC;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction
endpackage
`default_nettype wire

/* rtl/core/mcdma_front.sv */
// Front: two-entry command queue.
`timescale 1ns / 1ps
`default_nettype none
module mcdma_front (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    output logic              in_ready,
    input  mcdma_pkg::cmd_t   in_cmd,
    output logic              q_valid,
    input  wire               q_ready,
    output mcdma_pkg::cmd_t   q_cmd
);
    import mcdma_pkg::*;

    cmd_t       mem_reg [QUEUE_DEPTH];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'(QUEUE_DEPTH));
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = mem_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule
`default_nettype wire

/* rtl/core/mcdma_back.sv */
// Back: channel register file, scheduler and address stepping.
`timescale 1ns / 1ps
`default_nettype none
module mcdma_back #(
    parameter int NUM_CHANNELS = mcdma_pkg::NUM_CHANNELS_DEF
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              c_valid,
    output logic             c_ready,
    input  mcdma_pkg::cmd_t  c_cmd,
    output logic             r_valid,
    input  wire              r_ready,
    output mcdma_pkg::res_t  r_res
);
    import mcdma_pkg::*;

    logic [31:0] src_start_reg [NUM_CHANNELS];
    logic [31:0] dst_start_reg [NUM_CHANNELS];
    logic [27:0] total_reg     [NUM_CHANNELS];
    logic [23:0] bsize_reg     [NUM_CHANNELS];
    logic [31:0] ctrl_reg      [NUM_CHANNELS];
    logic [31:0] cur_src_reg   [NUM_CHANNELS];
    logic [31:0] cur_dst_reg   [NUM_CHANNELS];
    logic [31:0] drq_reg;
    logic [7:0]  pend_reg;
    logic [24:0] bleft_reg;
    logic        inblk_reg;
    logic [2:0]  bchan_reg;

    logic [31:0] src_start_next [NUM_CHANNELS];
    logic [31:0] dst_start_next [NUM_CHANNELS];
    logic [27:0] total_next     [NUM_CHANNELS];
    logic [23:0] bsize_next     [NUM_CHANNELS];
    logic [31:0] ctrl_next      [NUM_CHANNELS];
    logic [31:0] cur_src_next   [NUM_CHANNELS];
    logic [31:0] cur_dst_next   [NUM_CHANNELS];
    logic [31:0] drq_next;
    logic [7:0]  pend_next;
    logic [24:0] bleft_next;
    logic        inblk_next;
    logic [2:0]  bchan_next;

    res_t res_reg, res_next;
    logic rv_reg;
    logic fire;

    assign c_ready = !rv_reg || r_ready;
    assign fire    = c_valid && c_ready;
    assign r_valid = rv_reg;
    assign r_res   = res_reg;

    always_comb
    begin
        logic        do_raise;
        logic [4:0]  line;
        logic [31:0] lbit;
        logic [31:0] old, cw, nsrc, ndst;
        logic [4:0]  mode;
        logic [2:0]  ch;
        logic        found, end_b;
        logic [27:0] tl;
        logic [24:0] bl;
        logic [7:0]  en;

        src_start_next = src_start_reg;
        dst_start_next = dst_start_reg;
        total_next     = total_reg;
        bsize_next     = bsize_reg;
        ctrl_next      = ctrl_reg;
        cur_src_next   = cur_src_reg;
        cur_dst_next   = cur_dst_reg;
        drq_next       = drq_reg;
        pend_next      = pend_reg;
        bleft_next     = bleft_reg;
        inblk_next     = inblk_reg;
        bchan_next     = bchan_reg;
        res_next       = '0;
        do_raise       = 1'b0;
        line           = c_cmd.drq_type;
        ch             = '0;
        found          = 1'b0;
        end_b          = 1'b0;
        old            = '0;
        cw             = '0;
        mode           = '0;
        nsrc           = '0;
        ndst           = '0;
        tl             = '0;
        bl             = '0;
        lbit           = '0;
        en             = '0;

        case (func_t'(c_cmd.func))
            FN_WR_SRC, FN_WR_DST, FN_WR_TOTAL, FN_WR_BLOCK, FN_WR_CTRL:
            begin
                for (int c = 0; c < NUM_CHANNELS; c++)
                begin
                    if (32'(c_cmd.chan) == c)
                    begin
                        unique case (func_t'(c_cmd.func))
                            FN_WR_SRC: src_start_next[c] = (src_start_reg[c]
                                & ~(c_cmd.write_mask & ADDR_MASK))
                                | (c_cmd.write_value & c_cmd.write_mask & ADDR_MASK);
                            FN_WR_DST: dst_start_next[c] = (dst_start_reg[c]
                                & ~(c_cmd.write_mask & ADDR_MASK))
                                | (c_cmd.write_value & c_cmd.write_mask & ADDR_MASK);
                            FN_WR_TOTAL: total_next[c] = (total_reg[c]
                                & ~c_cmd.write_mask[27:0])
                                | (c_cmd.write_value[27:0] & c_cmd.write_mask[27:0]);
                            FN_WR_BLOCK: bsize_next[c] = (bsize_reg[c]
                                & ~c_cmd.write_mask[23:0])
                                | (c_cmd.write_value[23:0] & c_cmd.write_mask[23:0]);
                            default:
                            begin
                                old = ctrl_reg[c];
                                cw  = (old & ~(c_cmd.write_mask & CTRL_MASK))
                                    | (c_cmd.write_value & c_cmd.write_mask & CTRL_MASK);
                                ctrl_next[c] = cw;
                                if (!old[31] && cw[31])
                                begin
                                    cur_src_next[c] = src_start_reg[c];
                                    cur_dst_next[c] = dst_start_reg[c];
                                    if (cw[28])
                                    begin
                                        do_raise = 1'b1;
                                        line     = cw[28:24];
                                    end
                                end
                            end
                        endcase
                    end
                end
            end
            FN_DRQ_SET: do_raise = 1'b1;
            FN_DRQ_CLR: drq_next = drq_reg & ~(32'd1 << c_cmd.drq_type);
            default:
            begin
                if (inblk_reg || pend_reg != 8'd0)
                begin
                    if (inblk_reg)
                    begin
                        ch = bchan_reg;
                    end
                    else
                    begin
                        ch = 3'd7;
                        for (int c = 7; c >= 0; c--)
                            if (pend_reg[c]) ch = 3'(c);
                    end
                    found = 1'b0;
                    for (int c = 0; c < NUM_CHANNELS; c++)
                    begin
                        if (32'(ch) == c)
                        begin
                            found = 1'b1;
                            cw = ctrl_reg[c];
                            res_next.xfer_channel = ch;
                            if (cw[11:10] == 2'd3)
                            begin
                                res_next.status = ST_SKIP;
                                pend_next[ch]   = 1'b0;
                                inblk_next      = 1'b0;
                            end
                            else
                            begin
                                nsrc = cur_src_reg[c];
                                bl   = bleft_reg;
                                if (!inblk_reg)
                                begin
                                    if (cw[14:13] == 2'd3)
                                        nsrc = FILL_BASE + 32'(ch) * FILL_STEP;
                                    bl = (bsize_reg[c] != 24'd0) ? {1'b0, bsize_reg[c]}
                                                                 : BLOCK_MAX;
                                    inblk_next = 1'b1;
                                    bchan_next = ch;
                                end
                                res_next.status   = ST_WORD;
                                res_next.src_addr = nsrc;
                                res_next.dst_addr = cur_dst_reg[c];
                                nsrc = nsrc + step_of(cw[14:13]);
                                ndst = cur_dst_reg[c] + step_of(cw[11:10]);
                                bl   = bl - 25'd1;
                                bleft_next = bl;
                                end_b = (bl == 25'd0);
                                if (cw[29] || cw[28])
                                begin
                                    if (end_b)
                                    begin
                                        res_next.irq_raise = cw[30];
                                        if (cw[28]) cw[31] = 1'b0;
                                    end
                                end
                                else
                                begin
                                    tl = total_reg[c] - 28'd1;
                                    total_next[c] = tl;
                                    if (tl == 28'd0)
                                    begin
                                        res_next.irq_raise = cw[30];
                                        cw[31] = 1'b0;
                                        end_b  = 1'b1;
                                    end
                                end
                                ctrl_next[c] = cw;
                                if (end_b)
                                begin
                                    res_next.block_end = 1'b1;
                                    if (cw[12]) ndst = dst_start_reg[c];
                                    if (cw[15]) nsrc = src_start_reg[c];
                                    pend_next[ch] = 1'b0;
                                    inblk_next    = 1'b0;
                                end
                                cur_src_next[c] = nsrc;
                                cur_dst_next[c] = ndst;
                            end
                        end
                    end
                    if (!found)
                    begin
                        // channel beyond the built range: nothing stored there
                        res_next.xfer_channel = ch;
                        res_next.status       = ST_SKIP;
                        pend_next[ch]         = 1'b0;
                        inblk_next            = 1'b0;
                    end
                end
            end
        endcase

        if (do_raise)
        begin
            lbit = 32'd1 << line;
            drq_next = drq_reg | lbit;
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                mode = ctrl_next[c][28:24];
                if (ctrl_next[c][31])
                begin
                    if (mode == line)
                        pend_next[c] = 1'b1;
                    else if (mode == MODE_PAIR)
                    begin
                        if (ctrl_next[c][4:0] == 5'h08 && (lbit & PAIR_A) != 0
                            && (drq_next & PAIR_A) == PAIR_A)
                            pend_next[c] = 1'b1;
                        if (ctrl_next[c][4:0] == 5'h10 && (lbit & PAIR_B) != 0
                            && (drq_next & PAIR_B) == PAIR_B)
                            pend_next[c] = 1'b1;
                    end
                end
            end
        end

        for (int c = 0; c < NUM_CHANNELS; c++)
            en[c] = ctrl_next[c][31];
        res_next.enabled_mask = en;
        res_next.pending_mask = pend_next;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                src_start_reg[c] <= '0;
                dst_start_reg[c] <= '0;
                total_reg[c]     <= '0;
                bsize_reg[c]     <= '0;
                ctrl_reg[c]      <= '0;
                cur_src_reg[c]   <= '0;
                cur_dst_reg[c]   <= '0;
            end
            drq_reg   <= '0;
            pend_reg  <= '0;
            bleft_reg <= '0;
            inblk_reg <= 1'b0;
            bchan_reg <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                drq_reg   <= drq_next;
                pend_reg  <= pend_next;
                inblk_reg <= inblk_next;
                bleft_reg <= bleft_next;
                bchan_reg <= bchan_next;
                for (int c = 0; c < NUM_CHANNELS; c++)
                begin
                    src_start_reg[c] <= src_start_next[c];
                    dst_start_reg[c] <= dst_start_next[c];
                    total_reg[c]     <= total_next[c];
                    bsize_reg[c]     <= bsize_next[c];
                    ctrl_reg[c]      <= ctrl_next[c];
                    cur_src_reg[c]   <= cur_src_next[c];
                    cur_dst_reg[c]   <= cur_dst_next[c];
                end
                rv_reg <= 1'b1;
            end
            else if (r_ready)
            begin
                rv_reg <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/core/multi_channel_dma_address_engine_top.sv */
// Eight-channel DMA address engine.
// Use: push commands on s_axis (register writes, DRQ set/clear, step ticks);
// every command gives exactly one result transaction on m_axis. A step tick
// issues one word transfer for the channel in its block, or else the lowest
// pending channel, as a source/destination address pair with status.
// Path: a command is written into a two-entry queue at accept; the back end
// then executes it from the queue and loads the result into the output
// register, which drives m_axis_tvalid.
// Throughput: one command per clock while m_axis_tready stays high; set by the
// back end updating the channel state as it accepts each command.
// Reset: all channel registers, DRQ lines, pending bits and block state
// clear; no result is pending.
// Stall: when m_axis_tready is low the output register holds, the back end
// stops, the queue fills and s_axis_tready drops once it is full.
`timescale 1ns / 1ps
`default_nettype none
`include "multi_channel_dma_address_engine_top_defines.svh"
module multi_channel_dma_address_engine_top #(
    parameter int NUM_CHANNELS = mcdma_pkg::NUM_CHANNELS_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // func[2:0], chan[5:3], write_mask[37:6], write_value[69:38],
    // drq_type[74:70], zero fill
    input  wire  [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // status[1:0], src_addr[33:2], dst_addr[65:34], xfer_channel[68:66],
    // block_end[69], irq_raise[70], enabled_mask[78:71], pending_mask[86:79]
    output logic [87:0] m_axis_tdata
);
    import mcdma_pkg::*;

    cmd_t in_cmd, q_cmd;
    res_t res;
    logic q_valid, q_ready;

    assign in_cmd.func        = s_axis_tdata[2:0];
    assign in_cmd.chan        = s_axis_tdata[5:3];
    assign in_cmd.write_mask  = s_axis_tdata[37:6];
    assign in_cmd.write_value = s_axis_tdata[69:38];
    assign in_cmd.drq_type    = s_axis_tdata[74:70];

    mcdma_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_cmd   (in_cmd),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd)
    );

    mcdma_back #(.NUM_CHANNELS(NUM_CHANNELS)) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .c_valid (q_valid),
        .c_ready (q_ready),
        .c_cmd   (q_cmd),
        .r_valid (m_axis_tvalid),
        .r_ready (m_axis_tready),
        .r_res   (res)
    );

    assign m_axis_tdata = {1'b0, res.pending_mask, res.enabled_mask, res.irq_raise,
                           res.block_end, res.xfer_channel, res.dst_addr,
                           res.src_addr, res.status};

    `DMA_ASSERT_IMPL(a_idle_zero, m_axis_tvalid && res.status == ST_NONE,
        res.src_addr == 32'd0 && res.block_end == 1'b0 && res.irq_raise == 1'b0)
    `DMA_ASSERT_IMPL(a_no_reserved, m_axis_tvalid, res.status != 2'd3)
    `DMA_ASSERT_IMPL(a_irq_only_word, m_axis_tvalid && res.irq_raise,
        res.status == ST_WORD && res.block_end)
    `DMA_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))
endmodule
`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for the eight-channel DMA address engine.
`timescale 1ns / 1ps
module testbench;
    import mcdma_pkg::*;

    typedef struct {
        logic [2:0]  func;
        logic [2:0]  chan;
        logic [31:0] mask;
        logic [31:0] value;
        logic [4:0]  line;
    } command_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    wire  s_axis_tready;
    logic [79:0] s_axis_tdata;
    wire  m_axis_tvalid;
    logic m_axis_tready;
    wire  [87:0] m_axis_tdata;

    multi_channel_dma_address_engine_top i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // channel model
    logic [31:0] src_start [8];
    logic [31:0] dst_start [8];
    logic [27:0] total_left [8];
    logic [23:0] block_size [8];
    logic [31:0] ctrl_word [8];
    logic [31:0] cur_src [8];
    logic [31:0] cur_dst [8];
    logic [31:0] drq_lines;
    logic [7:0]  run_pending;
    logic [24:0] words_left;
    logic        in_block;
    logic [2:0]  block_chan;

    command_t    pending_cmds [$];
    logic [87:0] expected_results [$];
    int          sender_idle_pct;
    int          receiver_idle_pct;
    bit          hold_sender;
    int          mismatches;

    always #1 clk = ~clk;

    function automatic logic [79:0] pack_cmd(command_t c);
        return {5'd0, c.line, c.value, c.mask, c.chan, c.func};
    endfunction

    function automatic bit channel_wants(int c, logic [4:0] line);
        logic [31:0] cw;
        logic [31:0] bitv;
        cw = ctrl_word[c];
        bitv = 32'd1 << line;
        if (!cw[31]) return 0;
        if (cw[28:24] == line) return 1;
        if (cw[28:24] != MODE_PAIR) return 0;
        if (cw[4:0] == 5'h08)
            return ((bitv & PAIR_A) != 0) && ((drq_lines & PAIR_A) == PAIR_A);
        if (cw[4:0] == 5'h10)
            return ((bitv & PAIR_B) != 0) && ((drq_lines & PAIR_B) == PAIR_B);
        return 0;
    endfunction

    function automatic void raise_drq(logic [4:0] line);
        drq_lines[line] = 1'b1;
        for (int c = 0; c < 8; c++)
            if (channel_wants(c, line)) run_pending[c] = 1'b1;
    endfunction

    function automatic logic [31:0] addr_step(logic [1:0] sel);
        if (sel == 2'd0) return 32'd4;
        if (sel == 2'd1) return 32'hFFFF_FFFC;
        return 32'd0;
    endfunction

    function automatic logic [87:0] predict_transfer(command_t cmd);
        logic [1:0]  status;
        logic [31:0] sa, da, cw, old, m;
        logic [2:0]  ch;
        logic        bend, irq, done;
        logic [7:0]  en;
        status = ST_NONE; sa = 0; da = 0; ch = 0; bend = 0; irq = 0; en = 0;
        case (func_t'(cmd.func))
            FN_WR_SRC:
                src_start[cmd.chan] = (src_start[cmd.chan] & ~(cmd.mask & ADDR_MASK))
                    | (cmd.value & cmd.mask & ADDR_MASK);
            FN_WR_DST:
                dst_start[cmd.chan] = (dst_start[cmd.chan] & ~(cmd.mask & ADDR_MASK))
                    | (cmd.value & cmd.mask & ADDR_MASK);
            FN_WR_TOTAL:
                total_left[cmd.chan] = (total_left[cmd.chan] & ~cmd.mask[27:0])
                    | (cmd.value[27:0] & cmd.mask[27:0]);
            FN_WR_BLOCK:
                block_size[cmd.chan] = (block_size[cmd.chan] & ~cmd.mask[23:0])
                    | (cmd.value[23:0] & cmd.mask[23:0]);
            FN_WR_CTRL: begin
                old = ctrl_word[cmd.chan];
                m = cmd.mask & CTRL_MASK;
                ctrl_word[cmd.chan] = (old & ~m) | (cmd.value & m);
                if (!old[31] && ctrl_word[cmd.chan][31]) begin
                    cur_src[cmd.chan] = src_start[cmd.chan];
                    cur_dst[cmd.chan] = dst_start[cmd.chan];
                    if (ctrl_word[cmd.chan][28]) raise_drq(ctrl_word[cmd.chan][28:24]);
                end
            end
            FN_DRQ_SET: raise_drq(cmd.line);
            FN_DRQ_CLR: drq_lines[cmd.line] = 1'b0;
            default: begin
                if (in_block || run_pending != 0) begin
                    if (in_block) ch = block_chan;
                    else begin
                        ch = 3'd7;
                        for (int c = 6; c >= 0; c--)
                            if (run_pending[c]) ch = 3'(c);
                    end
                    cw = ctrl_word[ch];
                    if (cw[11:10] == 2'd3) begin
                        status = ST_SKIP;
                        run_pending[ch] = 1'b0;
                        in_block = 0;
                    end else begin
                        if (!in_block) begin
                            if (cw[14:13] == 2'd3)
                                cur_src[ch] = FILL_BASE + 32'(ch) * FILL_STEP;
                            words_left = block_size[ch] != 0 ? {1'b0, block_size[ch]}
                                                             : BLOCK_MAX;
                            in_block = 1;
                            block_chan = ch;
                        end
                        status = ST_WORD;
                        sa = cur_src[ch];
                        da = cur_dst[ch];
                        cur_src[ch] += addr_step(cw[14:13]);
                        cur_dst[ch] += addr_step(cw[11:10]);
                        words_left = words_left - 25'd1;
                        done = (words_left == 0);
                        if (cw[29:28] != 0) begin
                            if (done) begin
                                irq = cw[30];
                                if (cw[28]) ctrl_word[ch][31] = 1'b0;
                            end
                        end else begin
                            total_left[ch] = total_left[ch] - 28'd1;
                            if (total_left[ch] == 0) begin
                                irq = cw[30];
                                ctrl_word[ch][31] = 1'b0;
                                done = 1;
                            end
                        end
                        if (done) begin
                            bend = 1;
                            if (ctrl_word[ch][12]) cur_dst[ch] = dst_start[ch];
                            if (ctrl_word[ch][15]) cur_src[ch] = src_start[ch];
                            run_pending[ch] = 1'b0;
                            in_block = 0;
                        end
                    end
                end
            end
        endcase
        for (int c = 0; c < 8; c++) en[c] = ctrl_word[c][31];
        return {1'b0, run_pending, en, irq, bend, ch, da, sa, status};
    endfunction

    function automatic void push_cmd(int unsigned f, int unsigned c, logic [31:0] m,
                                     logic [31:0] v, int unsigned l);
        command_t cmd;
        cmd.func = 3'(f); cmd.chan = 3'(c); cmd.mask = m; cmd.value = v;
        cmd.line = 5'(l);
        pending_cmds.push_back(cmd);
    endfunction

    function automatic logic [31:0] rand_ctrl();
        logic [31:0] cw;
        cw = $urandom;
        cw[31] = 1'b1;
        if ($urandom_range(0, 3) != 0) cw[29:28] = 2'($urandom_range(0, 2));
        if ($urandom_range(0, 9) != 0 && cw[11:10] == 2'd3) cw[11:10] = 2'd0;
        case ($urandom_range(0, 3))
            0: cw[28:24] = 5'h0F;
            1: cw[28:24] = 5'($urandom_range(16, 31));
            default: cw[28:24] = 5'($urandom_range(0, 15));
        endcase
        if (cw[28:24] == 5'h0F) cw[4:0] = $urandom_range(0, 1) ? 5'h08 : 5'h10;
        return cw;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        command_t cmd;
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pending_cmds.size() != 0 && !hold_sender
                && $urandom_range(0, 99) >= sender_idle_pct) begin
                cmd = pending_cmds.pop_front();
                expected_results.push_back(predict_transfer(cmd));
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pack_cmd(cmd);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        logic [87:0] exp_res;
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
                end else begin
                    exp_res = expected_results.pop_front();
                    if (exp_res !== m_axis_tdata) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: status %0d/%0d src %h/%h dst %h/%h ch %0d/%0d end %b/%b irq %b/%b en %h/%h pend %h/%h (exp/act)",
                                exp_res[1:0], m_axis_tdata[1:0], exp_res[33:2],
                                m_axis_tdata[33:2], exp_res[65:34], m_axis_tdata[65:34],
                                exp_res[68:66], m_axis_tdata[68:66], exp_res[69],
                                m_axis_tdata[69], exp_res[70], m_axis_tdata[70],
                                exp_res[78:71], m_axis_tdata[78:71], exp_res[86:79],
                                m_axis_tdata[86:79]);
                    end
                end
            end
            m_axis_tready <= $urandom_range(0, 99) >= receiver_idle_pct;
        end
    end

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int c;
        int n;
        clk = 0; rst_n = 0; mismatches = 0; hold_sender = 0;
        sender_idle_pct = 23; receiver_idle_pct = 88;
        s_axis_tvalid = 0; s_axis_tdata = '0; m_axis_tready = 0;
        for (int i = 0; i < 8; i++) begin
            src_start[i] = 0; dst_start[i] = 0; total_left[i] = 0; block_size[i] = 0;
            ctrl_word[i] = 0; cur_src[i] = 0; cur_dst[i] = 0;
        end
        drq_lines = 0; run_pending = 0; words_left = 0; in_block = 0; block_chan = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: idle step, extremes, fill, reserved step, paired lines
        push_cmd(FN_STEP, 0, '1, '1, 31);
        push_cmd(FN_WR_SRC, 7, '1, '1, 0);
        push_cmd(FN_WR_DST, 7, '1, 32'h0, 0);
        push_cmd(FN_WR_TOTAL, 7, '1, 32'd3, 0);
        push_cmd(FN_WR_BLOCK, 7, '1, 32'd2, 0);
        push_cmd(FN_WR_CTRL, 7, '1, 32'hC000_9000 | (32'h1F << 24) | (32'd1 << 13), 0);
        push_cmd(FN_STEP, 0, 0, 0, 0);
        push_cmd(FN_STEP, 0, 0, 0, 0);
        push_cmd(FN_DRQ_SET, 0, 0, 0, 31);
        push_cmd(FN_STEP, 0, 0, 0, 0);
        push_cmd(FN_WR_BLOCK, 0, '1, 32'd1, 0);
        push_cmd(FN_WR_CTRL, 0, '1, 32'hD000_0000 | (32'h05 << 24) | (32'd3 << 13), 0);
        push_cmd(FN_DRQ_SET, 0, 0, 0, 5);
        push_cmd(FN_STEP, 0, 0, 0, 0);
        push_cmd(FN_WR_CTRL, 1, '1, 32'h8000_0C00 | (32'h02 << 24), 0);
        push_cmd(FN_DRQ_SET, 0, 0, 0, 2);
        push_cmd(FN_STEP, 0, 0, 0, 0);
        push_cmd(FN_WR_CTRL, 2, '1, 32'hA000_0008 | (32'h0F << 24), 0);
        push_cmd(FN_DRQ_SET, 0, 0, 0, 6);
        push_cmd(FN_DRQ_SET, 0, 0, 0, 8);
        push_cmd(FN_STEP, 0, 0, 0, 0);
        push_cmd(FN_DRQ_CLR, 0, 0, 0, 8);
        push_cmd(FN_WR_CTRL, 3, '1, 32'hA000_0010 | (32'h0F << 24), 0);
        push_cmd(FN_DRQ_SET, 0, 0, 0, 9);
        push_cmd(FN_DRQ_SET, 0, 0, 0, 10);

        for (int phase = 0; phase < 3; phase++) begin
            if (phase != 0) wait_drained();
            if (phase == 1) begin
                sender_idle_pct = 88; receiver_idle_pct = 23;
                // hold off until every result is in
                hold_sender = 1;
                wait_drained();
                hold_sender = 0;
            end
            if (phase == 2) begin
                sender_idle_pct = 0; receiver_idle_pct = 0;
            end
            n = 0;
            while (n < 270) begin
                c = $urandom_range(0, 7);
                case ($urandom_range(0, 9))
                    0: push_cmd(FN_WR_SRC, c, $urandom, $urandom, $urandom);
                    1: push_cmd(FN_WR_DST, c, $urandom, $urandom, $urandom);
                    2: push_cmd(FN_WR_TOTAL, c, $urandom_range(0, 1) ? '1 : $urandom,
                                $urandom_range(0, 1) ? $urandom_range(0, 6) : $urandom,
                                $urandom);
                    3: push_cmd(FN_WR_BLOCK, c, $urandom_range(0, 1) ? '1 : $urandom,
                                $urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom,
                                $urandom);
                    4: push_cmd(FN_WR_CTRL, c, $urandom_range(0, 3) ? '1 : $urandom,
                                $urandom_range(0, 4) ? rand_ctrl() : $urandom, $urandom);
                    5: push_cmd(FN_DRQ_SET, $urandom, $urandom, $urandom,
                                $urandom_range(0, 1) ? $urandom_range(5, 10) : $urandom);
                    6: push_cmd(FN_DRQ_CLR, $urandom, $urandom, $urandom, $urandom);
                    default: push_cmd(FN_STEP, $urandom, $urandom, $urandom, $urandom);
                endcase
                n++;
            end
        end
        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #500000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
